### design/plq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_pkg
// Shared widths, codes and state type of the pooled linked queue manager.
// ----------------------------------------------------------------------------
package plq_pkg;

  localparam int MODE_W  = 2;
  localparam int ENTRY_W = 10;
  localparam int STAT_W  = 2;
  localparam int SIZE_W  = 11;
  localparam int SLOT_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_WRONG = 2'd2
  } status_t;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_FREE   = 2'd0,
    SLOT_ALLOC  = 2'd1,
    SLOT_LISTED = 2'd2
  } slot_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } fsm_t;

endpackage

### design/plq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_if
// Request and response channels: valid/ready handshake plus word payload.
// ----------------------------------------------------------------------------
interface plq_in_if import plq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [ENTRY_W-1:0] entry;

  modport source (output valid, output mode, output entry, input ready);
  modport sink   (input valid, input mode, input entry, output ready);
endinterface

interface plq_out_if import plq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [ENTRY_W-1:0] given_entry;
  logic [SIZE_W-1:0]  list_size;
  logic               head_valid;
  logic [ENTRY_W-1:0] head_entry;
  logic [ENTRY_W-1:0] tail_entry;

  modport source (output valid, output status, output given_entry, output list_size,
                  output head_valid, output head_entry, output tail_entry, input ready);
  modport sink   (input valid, input status, input given_entry, input list_size,
                  input head_valid, input head_entry, input tail_entry, output ready);
endinterface

### design/plq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module plq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/plq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_ctrl
// Sequencer: init sweep, read of the link words, two write phases, response.
// ----------------------------------------------------------------------------
module plq_ctrl import plq_pkg::*; #(
  parameter int POOL_ENTRIES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  plq_in_if.sink                            in_req,
  plq_out_if.source                         out_rsp,
  output logic                              rd_en,
  output logic [$clog2(POOL_ENTRIES)-1:0]   rd_addr,
  output logic                              pv_we,
  output logic [$clog2(POOL_ENTRIES)-1:0]   pv_waddr,
  output logic [$clog2(POOL_ENTRIES):0]     pv_wdata,
  input  logic [$clog2(POOL_ENTRIES):0]     pv_rdata,
  output logic                              nx_we,
  output logic [$clog2(POOL_ENTRIES)-1:0]   nx_waddr,
  output logic [$clog2(POOL_ENTRIES):0]     nx_wdata,
  input  logic [$clog2(POOL_ENTRIES):0]     nx_rdata,
  output logic                              st_we,
  output logic [$clog2(POOL_ENTRIES)-1:0]   st_waddr,
  output logic [SLOT_W-1:0]                 st_wdata,
  input  logic [SLOT_W-1:0]                 st_rdata
);

  localparam int AW = $clog2(POOL_ENTRIES);
  localparam int LW = AW + 1;
  localparam logic [LW-1:0] NONE     = LW'(POOL_ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(POOL_ENTRIES - 1);

  fsm_t state_r, state_nxt;

  logic [AW-1:0] init_cnt_r;
  logic [LW-1:0] free_top_r, free_top_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] tail_r, tail_nxt;
  logic [LW-1:0] count_r, count_nxt;

  logic [MODE_W-1:0] mode_r;
  logic [AW-1:0]     entry_r;
  logic              in_pool_r;

  logic [STAT_W-1:0]  res_status_r;
  logic [ENTRY_W-1:0] res_given_r;

  logic          fin_pv_we_r, fin_nx_we_r;
  logic [AW-1:0] fin_pv_addr_r, fin_nx_addr_r;
  logic [LW-1:0] fin_pv_data_r, fin_nx_data_r;

  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [ENTRY_W-1:0] out_given_r;
  logic [SIZE_W-1:0]  out_size_r;
  logic               out_hv_r;
  logic [ENTRY_W-1:0] out_head_r;
  logic [ENTRY_W-1:0] out_tail_r;

  logic          in_fire, in_pool_c, out_load;
  logic [AW-1:0] entry_addr_c;

  logic [STAT_W-1:0]  ex_status;
  logic [ENTRY_W-1:0] ex_given;
  logic               ex_pv_we, ex_nx_we, ex_st_we;
  logic [AW-1:0]      ex_pv_addr, ex_nx_addr, ex_st_addr;
  logic [LW-1:0]      ex_pv_data, ex_nx_data;
  logic [SLOT_W-1:0]  ex_st_data;
  logic               fin_pv_we, fin_nx_we;
  logic [AW-1:0]      fin_pv_addr, fin_nx_addr;
  logic [LW-1:0]      fin_pv_data, fin_nx_data;

  assign in_fire      = in_req.valid && in_req.ready;
  assign in_pool_c    = 32'(in_req.entry) < 32'(POOL_ENTRIES);
  assign entry_addr_c = in_pool_c ? AW'(in_req.entry) : '0;
  assign out_load     = (state_r == ST_FIN) && (!out_valid_r || out_rsp.ready);

  // operation decode on the link words read at accept
  always_comb begin
    ex_status    = STAT_WRONG;
    ex_given     = '0;
    free_top_nxt = free_top_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    ex_pv_we     = 1'b0;
    ex_pv_addr   = entry_r;
    ex_pv_data   = NONE;
    ex_nx_we     = 1'b0;
    ex_nx_addr   = entry_r;
    ex_nx_data   = NONE;
    ex_st_we     = 1'b0;
    ex_st_addr   = entry_r;
    ex_st_data   = SLOT_FREE;
    fin_pv_we    = 1'b0;
    fin_pv_addr  = entry_r;
    fin_pv_data  = NONE;
    fin_nx_we    = 1'b0;
    fin_nx_addr  = entry_r;
    fin_nx_data  = NONE;
    unique case (mode_r)
      MODE_ALLOC: begin
        if (free_top_r == NONE) begin
          ex_status = STAT_EMPTY;
        end else begin
          ex_status    = STAT_DONE;
          ex_given     = ENTRY_W'(free_top_r);
          free_top_nxt = nx_rdata;
          ex_pv_we     = 1'b1;
          ex_pv_addr   = free_top_r[AW-1:0];
          ex_nx_we     = 1'b1;
          ex_nx_addr   = free_top_r[AW-1:0];
          ex_st_we     = 1'b1;
          ex_st_addr   = free_top_r[AW-1:0];
          ex_st_data   = SLOT_ALLOC;
        end
      end
      MODE_APPEND: begin
        if (in_pool_r && st_rdata == SLOT_ALLOC) begin
          ex_status  = STAT_DONE;
          ex_pv_we   = 1'b1;
          ex_pv_data = tail_r;
          ex_nx_we   = 1'b1;
          ex_st_we   = 1'b1;
          ex_st_data = SLOT_LISTED;
          if (tail_r != NONE) begin
            fin_nx_we   = 1'b1;
            fin_nx_addr = tail_r[AW-1:0];
            fin_nx_data = LW'(entry_r);
          end else begin
            head_nxt = LW'(entry_r);
          end
          tail_nxt  = LW'(entry_r);
          count_nxt = LW'(count_r + 1'b1);
        end
      end
      MODE_REMOVE: begin
        if (in_pool_r && st_rdata == SLOT_LISTED) begin
          ex_status = STAT_DONE;
          if (pv_rdata != NONE) begin
            ex_nx_we   = 1'b1;
            ex_nx_addr = pv_rdata[AW-1:0];
            ex_nx_data = nx_rdata;
          end else begin
            head_nxt = nx_rdata;
          end
          if (nx_rdata != NONE) begin
            ex_pv_we   = 1'b1;
            ex_pv_addr = nx_rdata[AW-1:0];
            ex_pv_data = pv_rdata;
          end else begin
            tail_nxt = pv_rdata;
          end
          ex_st_we     = 1'b1;
          ex_st_data   = SLOT_FREE;
          fin_pv_we    = 1'b1;
          fin_nx_we    = 1'b1;
          fin_nx_data  = free_top_r;
          free_top_nxt = LW'(entry_r);
          if (count_r != '0) begin
            count_nxt = LW'(count_r - 1'b1);
          end
        end
      end
      default: begin
        ex_status = STAT_WRONG;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: if (init_cnt_r == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE: if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_FIN;
      ST_FIN:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_INIT;
    endcase
  end

  // outputs: handshake and memory ports
  always_comb begin
    in_req.ready = (state_r == ST_IDLE);
    rd_en        = in_fire;
    rd_addr      = (in_req.mode == MODE_ALLOC)
                   ? ((free_top_r == NONE) ? '0 : free_top_r[AW-1:0]) : entry_addr_c;
    pv_we    = 1'b0;
    pv_waddr = init_cnt_r;
    pv_wdata = NONE;
    nx_we    = 1'b0;
    nx_waddr = init_cnt_r;
    nx_wdata = NONE;
    st_we    = 1'b0;
    st_waddr = init_cnt_r;
    st_wdata = SLOT_FREE;
    unique case (state_r)
      ST_INIT: begin
        pv_we    = 1'b1;
        nx_we    = 1'b1;
        nx_wdata = (init_cnt_r == '0) ? NONE : LW'(init_cnt_r - 1'b1);
        st_we    = 1'b1;
      end
      ST_EXEC: begin
        pv_we    = ex_pv_we;
        pv_waddr = ex_pv_addr;
        pv_wdata = ex_pv_data;
        nx_we    = ex_nx_we;
        nx_waddr = ex_nx_addr;
        nx_wdata = ex_nx_data;
        st_we    = ex_st_we;
        st_waddr = ex_st_addr;
        st_wdata = ex_st_data;
      end
      ST_FIN: begin
        pv_we    = fin_pv_we_r;
        pv_waddr = fin_pv_addr_r;
        pv_wdata = fin_pv_data_r;
        nx_we    = fin_nx_we_r;
        nx_waddr = fin_nx_addr_r;
        nx_wdata = fin_nx_data_r;
      end
      default: begin
        pv_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_cnt_r  <= '0;
      free_top_r  <= LW'(POOL_ENTRIES - 1);
      head_r      <= NONE;
      tail_r      <= NONE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      fin_pv_we_r <= 1'b0;
      fin_nx_we_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_INIT) begin
        init_cnt_r <= AW'(init_cnt_r + 1'b1);
      end
      if (state_r == ST_EXEC) begin
        free_top_r  <= free_top_nxt;
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        count_r     <= count_nxt;
        fin_pv_we_r <= fin_pv_we;
        fin_nx_we_r <= fin_nx_we;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r    <= in_req.mode;
      entry_r   <= entry_addr_c;
      in_pool_r <= in_pool_c;
    end
    if (state_r == ST_EXEC) begin
      res_status_r  <= ex_status;
      res_given_r   <= ex_given;
      fin_pv_addr_r <= fin_pv_addr;
      fin_pv_data_r <= fin_pv_data;
      fin_nx_addr_r <= fin_nx_addr;
      fin_nx_data_r <= fin_nx_data;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_given_r  <= res_given_r;
      out_size_r   <= SIZE_W'(count_r);
      out_hv_r     <= (head_r != NONE);
      out_head_r   <= (head_r != NONE) ? ENTRY_W'(head_r) : '0;
      out_tail_r   <= (head_r != NONE) ? ENTRY_W'(tail_r) : '0;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.given_entry = out_given_r;
  assign out_rsp.list_size   = out_size_r;
  assign out_rsp.head_valid  = out_hv_r;
  assign out_rsp.head_entry  = out_head_r;
  assign out_rsp.tail_entry  = out_tail_r;

  a_head_tail_none: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NONE) == (tail_r == NONE))
    else $error("head and tail disagree on empty list");

  a_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == (head_r == NONE))
    else $error("list size does not match head");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NONE)
    else $error("list size above pool size");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !(pv_we || nx_we || st_we))
    else $error("memory write while idle");

  a_fire_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC))
    else $error("accepted word not executed");

endmodule

### design/pooled_linked_queue_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pooled_linked_queue_manager
// Slot pool with a free list and a doubly linked FIFO of live entries.
// ----------------------------------------------------------------------------
// Each request word goes from accept to response through the registered read
// of the prev/next/state memories, then two write phases, because a remove
// updates both neighbours and the freed slot through single-write-port link
// memories. A new word is accepted once the previous one has left its second
// write phase; the response register lets the next word enter while a
// response still waits. After reset an init sweep writes every slot before
// the first word is accepted.
module pooled_linked_queue_manager import plq_pkg::*; #(
  parameter int POOL_ENTRIES = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  plq_in_if.sink    in_req,
  plq_out_if.source out_rsp
);

  localparam int AW = $clog2(POOL_ENTRIES);
  localparam int LW = AW + 1;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              pv_we, nx_we, st_we;
  logic [AW-1:0]     pv_waddr, nx_waddr, st_waddr;
  logic [LW-1:0]     pv_wdata, nx_wdata, pv_rdata, nx_rdata;
  logic [SLOT_W-1:0] st_wdata, st_rdata;

  plq_ctrl #(.POOL_ENTRIES(POOL_ENTRIES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_rsp  (out_rsp),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .pv_we    (pv_we),
    .pv_waddr (pv_waddr),
    .pv_wdata (pv_wdata),
    .pv_rdata (pv_rdata),
    .nx_we    (nx_we),
    .nx_waddr (nx_waddr),
    .nx_wdata (nx_wdata),
    .nx_rdata (nx_rdata),
    .st_we    (st_we),
    .st_waddr (st_waddr),
    .st_wdata (st_wdata),
    .st_rdata (st_rdata)
  );

  plq_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(LW)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (pv_rdata)
  );

  plq_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(LW)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (nx_rdata)
  );

  plq_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(SLOT_W)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

endmodule

### tb/sv/pooled_linked_queue_manager_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pooled_linked_queue_manager_test
// Drives allocate, append, remove and unused-mode words into the queue
// manager. A shadow copy of the free list and the live list predicts every
// response, which is then checked field by field. The run covers directed
// corner cases, mixed random traffic under several idle/stall patterns with
// a long response stall, and a final pool drain until allocate runs dry.
// ----------------------------------------------------------------------------
module pooled_linked_queue_manager_test;
  import plq_pkg::*;

  localparam int POOL_ENTRIES = 1024;
  localparam logic [SIZE_W-1:0] LINK_NONE = SIZE_W'(POOL_ENTRIES);
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int MIXED_PER_PHASE = 150;

  typedef struct {
    status_t             status;
    logic [ENTRY_W-1:0]  given;
    logic [SIZE_W-1:0]   size;
    logic                hv;
    logic [ENTRY_W-1:0]  head;
    logic [ENTRY_W-1:0]  tail;
  } rsp_word_t;

  class plq_shadow;
    logic [SIZE_W-1:0] back_ptr [POOL_ENTRIES];
    logic [SIZE_W-1:0] fwd_ptr [POOL_ENTRIES];
    slot_t             slot_use [POOL_ENTRIES];
    logic [SIZE_W-1:0] free_head;
    logic [SIZE_W-1:0] front;
    logic [SIZE_W-1:0] back;
    int                linked_count;
    rsp_word_t         pending_rsp[$];
    int                fail_count;
    int                n_requests;
    int                n_checked;
    int                n_empty;
    int                n_wrong;
    int                peak_size;

    function void reset_state();
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        back_ptr[i] = LINK_NONE;
        fwd_ptr[i]  = (i == 0) ? LINK_NONE : SIZE_W'(i - 1);
        slot_use[i] = SLOT_FREE;
      end
      free_head    = SIZE_W'(POOL_ENTRIES - 1);
      front        = LINK_NONE;
      back         = LINK_NONE;
      linked_count = 0;
    endfunction

    task report(input string what);
      fail_count++;
      $display("MISMATCH: %s", what);
    endtask

    // Accepted request word: update the shadow lists and queue the response.
    function void log_request(input logic [MODE_W-1:0] m, input logic [ENTRY_W-1:0] e);
      rsp_word_t w;
      logic [SIZE_W-1:0] s, p, n;
      w.status = STAT_WRONG;
      w.given  = '0;
      case (m)
        MODE_ALLOC: begin
          if (free_head == LINK_NONE) begin
            w.status = STAT_EMPTY;
          end else begin
            s = free_head;
            free_head = fwd_ptr[s];
            back_ptr[s] = LINK_NONE;
            fwd_ptr[s] = LINK_NONE;
            slot_use[s] = SLOT_ALLOC;
            w.given = s[ENTRY_W-1:0];
            w.status = STAT_DONE;
          end
        end
        MODE_APPEND: begin
          if (slot_use[e] == SLOT_ALLOC) begin
            back_ptr[e] = back;
            fwd_ptr[e] = LINK_NONE;
            if (back != LINK_NONE) fwd_ptr[back[ENTRY_W-1:0]] = {1'b0, e};
            else front = {1'b0, e};
            back = {1'b0, e};
            slot_use[e] = SLOT_LISTED;
            linked_count++;
            w.status = STAT_DONE;
          end
        end
        MODE_REMOVE: begin
          if (slot_use[e] == SLOT_LISTED) begin
            p = back_ptr[e];
            n = fwd_ptr[e];
            if (p != LINK_NONE) fwd_ptr[p[ENTRY_W-1:0]] = n;
            else front = n;
            if (n != LINK_NONE) back_ptr[n[ENTRY_W-1:0]] = p;
            else back = p;
            back_ptr[e] = LINK_NONE;
            fwd_ptr[e] = free_head;
            free_head = {1'b0, e};
            slot_use[e] = SLOT_FREE;
            if (linked_count > 0) linked_count--;
            w.status = STAT_DONE;
          end
        end
        default: w.status = STAT_WRONG;
      endcase
      w.size = SIZE_W'(linked_count);
      w.hv   = (front != LINK_NONE);
      w.head = w.hv ? front[ENTRY_W-1:0] : '0;
      w.tail = w.hv ? back[ENTRY_W-1:0] : '0;
      if (w.status == STAT_EMPTY) n_empty++;
      if (w.status == STAT_WRONG) n_wrong++;
      if (linked_count > peak_size) peak_size = linked_count;
      n_requests++;
      pending_rsp.insert(pending_rsp.size(), w);
    endfunction

    task check_response(input logic [STAT_W-1:0] st, input logic [ENTRY_W-1:0] given,
                        input logic [SIZE_W-1:0] size, input logic hv,
                        input logic [ENTRY_W-1:0] head, input logic [ENTRY_W-1:0] tail);
      rsp_word_t w;
      if (pending_rsp.size() == 0) begin
        report($sformatf("response word with none expected, status %0d", st));
        return;
      end
      w = pending_rsp.pop_front();
      n_checked++;
      if (st !== w.status)
        report($sformatf("word %0d status %0d, expected %0d", n_checked, st, w.status));
      if (given !== w.given)
        report($sformatf("word %0d given_entry %0d, expected %0d", n_checked, given, w.given));
      if (size !== w.size)
        report($sformatf("word %0d list_size %0d, expected %0d", n_checked, size, w.size));
      if (hv !== w.hv)
        report($sformatf("word %0d head_valid %0d, expected %0d", n_checked, hv, w.hv));
      if (head !== w.head)
        report($sformatf("word %0d head_entry %0d, expected %0d", n_checked, head, w.head));
      if (tail !== w.tail)
        report($sformatf("word %0d tail_entry %0d, expected %0d", n_checked, tail, w.tail));
    endtask

    // Random allocated-but-unlisted slot, or -1 if there is none.
    function int find_allocated();
      int start;
      start = $urandom_range(0, POOL_ENTRIES - 1);
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        if (slot_use[(start + i) % POOL_ENTRIES] == SLOT_ALLOC)
          return (start + i) % POOL_ENTRIES;
      end
      return -1;
    endfunction

    function int listed_at(input int k);
      logic [SIZE_W-1:0] s;
      s = front;
      for (int i = 0; i < k; i++) s = fwd_ptr[s[ENTRY_W-1:0]];
      return int'(s);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  plq_in_if  in_req ();
  plq_out_if out_rsp ();

  plq_shadow book;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  pooled_linked_queue_manager #(.POOL_ENTRIES(POOL_ENTRIES)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pooled_linked_queue_manager verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready)
      book.check_response(out_rsp.status, out_rsp.given_entry, out_rsp.list_size,
                          out_rsp.head_valid, out_rsp.head_entry, out_rsp.tail_entry);
  end

  // Response side: random stalls, plus a long hold-off on request.
  initial begin
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [ENTRY_W-1:0] e);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.mode  <= m;
    in_req.entry <= e;
    do @(posedge clk); while (!in_req.ready);
    book.log_request(m, e);
    @(negedge clk);
  endtask

  task automatic send_remove_listed();
    int k;
    case ($urandom_range(0, 2))
      0: k = 0;
      1: k = book.linked_count - 1;
      default: k = $urandom_range(0, book.linked_count - 1);
    endcase
    send_word(MODE_REMOVE, ENTRY_W'(book.listed_at(k)));
  endtask

  task automatic send_mixed();
    int r, e;
    r = $urandom_range(0, 99);
    if (book.linked_count > 48 && r < 58) r = 70;
    if (r < 28) begin
      send_word(MODE_ALLOC, ENTRY_W'($urandom));
    end else if (r < 58) begin
      e = book.find_allocated();
      if (e < 0) send_word(MODE_ALLOC, ENTRY_W'($urandom));
      else send_word(MODE_APPEND, ENTRY_W'(e));
    end else if (r < 85) begin
      if (book.linked_count == 0) send_word(MODE_ALLOC, ENTRY_W'($urandom));
      else send_remove_listed();
    end else if (r < 91) begin
      send_word(MODE_APPEND, ENTRY_W'($urandom));
    end else if (r < 97) begin
      send_word(MODE_REMOVE, ENTRY_W'($urandom));
    end else begin
      send_word(MODE_UNUSED, ENTRY_W'($urandom));
    end
  endtask

  initial begin
    int e;
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.mode  = MODE_ALLOC;
    in_req.entry = '0;
    book = new;
    book.reset_state();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: wrong-state cases, head/middle/tail removal, unused mode
    send_word(MODE_REMOVE, 10'd0);
    send_word(MODE_APPEND, 10'd1023);
    send_word(MODE_ALLOC, 10'd1023);
    send_word(MODE_REMOVE, 10'd1023);
    send_word(MODE_APPEND, 10'd1023);
    send_word(MODE_APPEND, 10'd1023);
    send_word(MODE_ALLOC, 10'd0);
    send_word(MODE_APPEND, 10'd1022);
    send_word(MODE_ALLOC, 10'd0);
    send_word(MODE_APPEND, 10'd1021);
    send_word(MODE_REMOVE, 10'd1022);
    send_word(MODE_REMOVE, 10'd1023);
    send_word(MODE_ALLOC, 10'd512);
    send_word(MODE_ALLOC, 10'd511);
    send_word(MODE_APPEND, 10'd1023);
    send_word(MODE_APPEND, 10'd1022);
    send_word(MODE_REMOVE, 10'd1022);
    send_word(MODE_REMOVE, 10'd1021);
    send_word(MODE_REMOVE, 10'd1023);
    send_word(MODE_REMOVE, 10'd1023);
    send_word(MODE_APPEND, 10'd0);
    send_word(MODE_UNUSED, 10'd0);
    send_word(MODE_UNUSED, 10'd1023);

    // mixed traffic, one idle/stall pattern per phase
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      if (ph == 0) hold_req = 1'b1;
      repeat (MIXED_PER_PHASE) send_mixed();
    end

    // drain the pool until allocate reports empty, then keep mixing
    send_idle_pct = 10;
    recv_stall_pct = 10;
    while (book.free_head != LINK_NONE) begin
      send_word(MODE_ALLOC, ENTRY_W'($urandom));
      if ($urandom_range(0, 99) < 30) begin
        e = book.find_allocated();
        send_word(MODE_APPEND, ENTRY_W'(e));
      end
    end
    repeat (3) send_word(MODE_ALLOC, ENTRY_W'($urandom));
    repeat (60) send_mixed();
    in_req.valid <= 1'b0;

    while (book.pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d request words, checked %0d responses (%0d pool-empty, %0d wrong-state).",
             book.n_requests, book.n_checked, book.n_empty, book.n_wrong);
    $display("Longest live list reached %0d entries; %0d mismatches seen.",
             book.peak_size, book.fail_count);
    if (book.fail_count == 0) begin
      $display("pooled_linked_queue_manager verification clean");
    end else begin
      $display("pooled_linked_queue_manager verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/plq_pkg.sv
design/plq_if.sv
design/plq_ram.sv
design/plq_ctrl.sv
design/pooled_linked_queue_manager.sv
tb/sv/pooled_linked_queue_manager_test.sv
